FILE: rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared types, constants and arithmetic for euler_to_quaternion
// Fixed-point formats, payload structs and per-stage data carried by the cells.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int ANGLE_W      = 16;
	localparam int QUAT_W       = 16;
	localparam int FRAC_W       = 30;
	localparam int TAYLOR_TERMS = 8;
	localparam int SQRT_STEPS   = 32;
	localparam int QUO_W        = QUAT_W - 1;
	localparam int ANGLE_SHIFT  = 32 - ANGLE_W;

	localparam logic signed [33:0] FX_PI      = 34'sd3373259426;
	localparam logic signed [33:0] FX_HALF_PI = 34'sd1686629713;
	localparam logic [31:0]        FX_ONE     = 32'h4000_0000;
	localparam logic signed [65:0] TRUNC_BIAS = (66'sd1 <<< FRAC_W) - 66'sd1;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [QUAT_W-1:0]  qcomp_t;
	typedef logic signed [32:0]        fx_t;

	typedef struct packed {
		angle_t roll_angle;
		angle_t pitch_angle;
		angle_t yaw_angle;
	} angles_t;

	typedef struct packed {
		qcomp_t quat_w;
		qcomp_t quat_x;
		qcomp_t quat_y;
		qcomp_t quat_z;
	} quat_t;

	// reduced half angle, 0 .. pi/2 in Q.30, with the sign fixups to apply later
	typedef struct packed {
		logic [30:0] x;
		logic        neg;
		logic        flip;
	} red_t;

	// data moving along the series cells: lanes 0..2 are roll, pitch, yaw
	typedef struct packed {
		red_t [2:0]       ang;
		logic [2:0][31:0] x2;
		logic [2:0][31:0] ts;
		logic [2:0][31:0] tc;
	} trig_t;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] res;
		fx_t [3:0]   comp;
	} root_t;

	typedef struct packed {
		logic [3:0][63:0]      rem;
		logic [3:0][QUO_W-1:0] quo;
		logic [31:0]           norm;
		logic [3:0]            sgn;
	} quot_t;

	function automatic int sin_div(input int k);
		return (2 * k) * (2 * k + 1);
	endfunction

	function automatic int cos_div(input int k);
		return (2 * k - 1) * (2 * k);
	endfunction

	// Q.30 product, truncated toward zero
	function automatic fx_t fx_mul(input fx_t a, input fx_t b);
		logic signed [65:0] p;
		logic signed [65:0] pb;
		p  = a * b;
		pb = p + (p[65] ? TRUNC_BIAS : 66'sd0);
		return pb[62:30];
	endfunction

	// half angle into 0 .. pi/2
	function automatic red_t reduce_half(input angle_t ang);
		logic signed [33:0] h;
		red_t r;
		h      = 34'(ang) <<< ANGLE_SHIFT;
		r.flip = 1'b0;
		if (h > FX_HALF_PI) begin
			h      = h - FX_PI;
			r.flip = 1'b1;
		end else if (h < -FX_HALF_PI) begin
			h      = h + FX_PI;
			r.flip = 1'b1;
		end
		r.neg = h[33];
		if (h[33]) begin
			h = -h;
		end
		r.x = h[30:0];
		return r;
	endfunction

endpackage

FILE: rtl/e2q_horner_cell.sv
// ----------------------------------------------------------------------------
// e2q_horner_cell: one series step for sine and cosine of three angles
// t <= 1 - (x2 * t) / d, three register stages: product, reciprocal, correct.
// ----------------------------------------------------------------------------
module e2q_horner_cell #(
	parameter int K = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  e2q_pkg::trig_t in_d,
	output logic           out_vld,
	output e2q_pkg::trig_t out_d
);
	import e2q_pkg::*;

	localparam int LANES = 6;
	localparam logic [31:0] DS = 32'(sin_div(K));
	localparam logic [31:0] DC = 32'(cos_div(K));
	localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
	localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
	// lanes 0..2 sine, 3..5 cosine
	localparam logic [LANES-1:0][31:0] DIV = {DC, DC, DC, DS, DS, DS};
	localparam logic [LANES-1:0][31:0] MUL = {MC, MC, MC, MS, MS, MS};

	logic vld_s1, vld_s2, vld_s3;
	trig_t d_s1, d_s2, d_s3, nxt;
	logic [LANES-1:0][31:0] p_s1, p_s2, qa_s2;
	logic [LANES-1:0][31:0] p_c, qa_c, r_c, q_c;
	logic [2:0][62:0] prod_s, prod_c;
	logic [LANES-1:0][63:0] recip, back;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod_s[a] = 63'(in_d.x2[a]) * 63'(in_d.ts[a][30:0]);
			prod_c[a] = 63'(in_d.x2[a]) * 63'(in_d.tc[a][30:0]);
			p_c[a]     = prod_s[a][61:30];
			p_c[a + 3] = prod_c[a][61:30];
		end
	end

	// quotient estimate is low by at most one
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			recip[l] = 64'(p_s1[l]) * 64'(MUL[l]);
			qa_c[l]  = recip[l][63:32];
		end
	end

	always_comb begin
		nxt = d_s2;
		for (int l = 0; l < LANES; l++) begin
			back[l] = 64'(qa_s2[l]) * 64'(DIV[l]);
			r_c[l]  = p_s2[l] - back[l][31:0];
			q_c[l]  = qa_s2[l] + {31'b0, (r_c[l] >= DIV[l])};
		end
		for (int a = 0; a < 3; a++) begin
			nxt.ts[a] = FX_ONE - q_c[a];
			nxt.tc[a] = FX_ONE - q_c[a + 3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= in_d;
			p_s1  <= p_c;
			d_s2  <= d_s1;
			p_s2  <= p_s1;
			qa_s2 <= qa_c;
			d_s3  <= nxt;
		end
	end

	assign out_vld = vld_s3;
	assign out_d   = d_s3;

endmodule

FILE: rtl/e2q_sqrt_cell.sv
// ----------------------------------------------------------------------------
// e2q_sqrt_cell: one digit of the integer square root of the sum of squares
// Trial subtract of res + bit, one result bit per cell.
// ----------------------------------------------------------------------------
module e2q_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  e2q_pkg::root_t in_d,
	output logic           out_vld,
	output e2q_pkg::root_t out_d
);
	import e2q_pkg::*;

	localparam logic [63:0] STEP_BIT = 64'd1 << (62 - 2 * STEP);

	logic vld_s1;
	root_t d_s1, nxt;
	logic [63:0] trial;

	always_comb begin
		nxt   = in_d;
		trial = in_d.res + STEP_BIT;
		if (in_d.v >= trial) begin
			nxt.v   = in_d.v - trial;
			nxt.res = (in_d.res >> 1) + STEP_BIT;
		end else begin
			nxt.res = in_d.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_d   = d_s1;

endmodule

FILE: rtl/e2q_div_cell.sv
// ----------------------------------------------------------------------------
// e2q_div_cell: one quotient bit of component / norm for all four components
// Restoring step against norm shifted to this cell's bit position.
// ----------------------------------------------------------------------------
module e2q_div_cell #(
	parameter int J = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  e2q_pkg::quot_t in_d,
	output logic           out_vld,
	output e2q_pkg::quot_t out_d
);
	import e2q_pkg::*;

	logic vld_s1;
	quot_t d_s1, nxt;
	logic [63:0] shifted;

	always_comb begin
		nxt     = in_d;
		shifted = 64'(in_d.norm) << J;
		for (int l = 0; l < 4; l++) begin
			if (in_d.rem[l] >= shifted) begin
				nxt.rem[l]    = in_d.rem[l] - shifted;
				nxt.quo[l][J] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_d   = d_s1;

endmodule

FILE: rtl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion: roll/pitch/yaw to normalized Q1.14 quaternion
// The pipeline is made up mainly of the 24-stage series chain, the 32-cell
// square root chain and the 15-cell divider chain.
// Throughput: one beat per cycle; the whole pipe holds only when a result
// reaches the output register while it is still full and not taken.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             angles_valid,
	output logic             angles_ready,
	input  e2q_pkg::angles_t angles,
	output logic             quat_valid,
	input  logic             quat_ready,
	output e2q_pkg::quat_t   quat
);
	import e2q_pkg::*;

	localparam logic [QUAT_W-1:0] LIM = QUAT_W'(1) << (QUAT_W - 2);

	logic en, vld_last;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	red_t [2:0] red_c, red_s1;
	trig_t tr_c, tr_s2;
	logic [2:0][61:0] xsq;

	trig_t hn_d [0:TAYLOR_TERMS];
	logic [TAYLOR_TERMS:0] hn_v;

	fx_t [2:0] sn_c, cs_c, sn_s3, cs_s3;
	fx_t bs, bc;
	fx_t cc_s4, ss_s4, sc_s4, csn_s4, s3_s4, c3_s4;
	fx_t [7:0] pp_c, pp_s5;
	fx_t [3:0] comp_c, comp_s6, comp_s7;
	logic signed [65:0] sqf;
	logic [3:0][63:0] sq_c, sq_s7;
	root_t rt_s8;

	root_t rt_d [0:SQRT_STEPS];
	logic [SQRT_STEPS:0] rt_v;

	quot_t dv_c, dv_s9;
	fx_t cval;
	logic [32:0] mag;

	quot_t dv_d [0:QUO_W];
	logic [QUO_W:0] dv_v;

	logic [3:0][QUAT_W-1:0] oc;
	logic [QUAT_W-1:0] qv;
	quat_t out_q;
	logic out_vld_q;

	assign vld_last     = dv_v[QUO_W];
	assign en           = ~(vld_last & out_vld_q & ~quat_ready);
	assign angles_ready = en;

	// front: halve and reduce each angle
	always_comb begin
		red_c[0] = reduce_half(angles.roll_angle);
		red_c[1] = reduce_half(angles.pitch_angle);
		red_c[2] = reduce_half(angles.yaw_angle);
	end

	always_comb begin
		tr_c.ang = red_s1;
		for (int a = 0; a < 3; a++) begin
			xsq[a]     = 62'(red_s1[a].x) * 62'(red_s1[a].x);
			tr_c.x2[a] = xsq[a][61:30];
			tr_c.ts[a] = FX_ONE;
			tr_c.tc[a] = FX_ONE;
		end
	end

	assign hn_d[0] = tr_s2;
	assign hn_v[0] = vld_s2;

	for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_horner
		e2q_horner_cell #(
			.K(TAYLOR_TERMS - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_vld (hn_v[i]),
			.in_d   (hn_d[i]),
			.out_vld(hn_v[i + 1]),
			.out_d  (hn_d[i + 1])
		);
	end

	// sine = x * series, cosine = series, then quadrant signs
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			bs = fx_mul(fx_t'({2'b00, hn_d[TAYLOR_TERMS].ang[a].x}),
				fx_t'({hn_d[TAYLOR_TERMS].ts[a][31], hn_d[TAYLOR_TERMS].ts[a]}));
			bc = fx_t'({hn_d[TAYLOR_TERMS].tc[a][31], hn_d[TAYLOR_TERMS].tc[a]});
			sn_c[a] = (hn_d[TAYLOR_TERMS].ang[a].neg ^ hn_d[TAYLOR_TERMS].ang[a].flip) ?
				-bs : bs;
			cs_c[a] = hn_d[TAYLOR_TERMS].ang[a].flip ? -bc : bc;
		end
	end

	always_comb begin
		pp_c[0] = fx_mul(cc_s4, c3_s4);
		pp_c[1] = fx_mul(ss_s4, s3_s4);
		pp_c[2] = fx_mul(sc_s4, c3_s4);
		pp_c[3] = fx_mul(csn_s4, s3_s4);
		pp_c[4] = fx_mul(csn_s4, c3_s4);
		pp_c[5] = fx_mul(sc_s4, s3_s4);
		pp_c[6] = fx_mul(cc_s4, s3_s4);
		pp_c[7] = fx_mul(ss_s4, c3_s4);
	end

	// w, x, y, z
	always_comb begin
		comp_c[0] = pp_s5[0] - pp_s5[1];
		comp_c[1] = pp_s5[2] + pp_s5[3];
		comp_c[2] = pp_s5[4] - pp_s5[5];
		comp_c[3] = pp_s5[6] + pp_s5[7];
	end

	always_comb begin
		sqf = '0;
		for (int l = 0; l < 4; l++) begin
			sqf     = $signed(comp_s6[l]) * $signed(comp_s6[l]);
			sq_c[l] = sqf[63:0];
		end
	end

	assign rt_d[0] = rt_s8;
	assign rt_v[0] = vld_s8;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		e2q_sqrt_cell #(
			.STEP(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_vld (rt_v[i]),
			.in_d   (rt_d[i]),
			.out_vld(rt_v[i + 1]),
			.out_d  (rt_d[i + 1])
		);
	end

	// dividend = |c| * 2^(QUAT_W-2) + norm/2 for round to nearest
	always_comb begin
		dv_c.norm = rt_d[SQRT_STEPS].res[31:0];
		cval      = '0;
		mag       = '0;
		for (int l = 0; l < 4; l++) begin
			cval        = rt_d[SQRT_STEPS].comp[l];
			mag         = cval[32] ? 33'(-cval) : 33'(cval);
			dv_c.sgn[l] = cval[32];
			dv_c.quo[l] = '0;
			dv_c.rem[l] = (64'(mag) << (QUAT_W - 2)) + 64'(dv_c.norm >> 1);
		end
	end

	assign dv_d[0] = dv_s9;
	assign dv_v[0] = vld_s9;

	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		e2q_div_cell #(
			.J(QUO_W - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_vld (dv_v[i]),
			.in_d   (dv_d[i]),
			.out_vld(dv_v[i + 1]),
			.out_d  (dv_d[i + 1])
		);
	end

	// saturate, zero norm gives zero, then sign
	always_comb begin
		qv = '0;
		for (int l = 0; l < 4; l++) begin
			qv = QUAT_W'(dv_d[QUO_W].quo[l]);
			if (qv > LIM) begin
				qv = LIM;
			end
			if (dv_d[QUO_W].norm == 32'd0) begin
				qv = '0;
			end
			if (dv_d[QUO_W].sgn[l]) begin
				qv = -qv;
			end
			oc[l] = qv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en) begin
				vld_s1 <= angles_valid;
				vld_s2 <= vld_s1;
				vld_s3 <= hn_v[TAYLOR_TERMS];
				vld_s4 <= vld_s3;
				vld_s5 <= vld_s4;
				vld_s6 <= vld_s5;
				vld_s7 <= vld_s6;
				vld_s8 <= vld_s7;
				vld_s9 <= rt_v[SQRT_STEPS];
			end
			if (en && vld_last) begin
				out_vld_q <= 1'b1;
			end else if (quat_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1  <= red_c;
			tr_s2   <= tr_c;
			sn_s3   <= sn_c;
			cs_s3   <= cs_c;
			cc_s4   <= fx_mul(cs_s3[0], cs_s3[1]);
			ss_s4   <= fx_mul(sn_s3[0], sn_s3[1]);
			sc_s4   <= fx_mul(sn_s3[0], cs_s3[1]);
			csn_s4  <= fx_mul(cs_s3[0], sn_s3[1]);
			s3_s4   <= sn_s3[2];
			c3_s4   <= cs_s3[2];
			pp_s5   <= pp_c;
			comp_s6 <= comp_c;
			comp_s7 <= comp_s6;
			sq_s7   <= sq_c;
			rt_s8.v    <= sq_s7[0] + sq_s7[1] + sq_s7[2] + sq_s7[3];
			rt_s8.res  <= '0;
			rt_s8.comp <= comp_s7;
			dv_s9   <= dv_c;
			if (vld_last) begin
				out_q.quat_w <= oc[0];
				out_q.quat_x <= oc[1];
				out_q.quat_y <= oc[2];
				out_q.quat_z <= oc[3];
			end
		end
	end

	assign quat_valid = out_vld_q;
	assign quat       = out_q;

endmodule

FILE: bench/euler_to_quaternion_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb: self-checking bench for the Euler to quaternion block
// Drives angle beats with random gaps and output stalls, predicts each
// normalized quaternion in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module euler_to_quaternion_tb;
	import e2q_pkg::*;

	localparam longint ONE_Q30  = 64'sd1 << 30;
	localparam longint PI_Q30   = 64'sd3373259426;
	localparam longint HPI_Q30  = 64'sd1686629713;
	localparam int     N_RANDOM = 750;
	localparam int     LIMIT    = 400000;

	class quat_scoreboard;
		quat_t pending[$];
		int    errors;

		function new();
			errors = 0;
		endfunction

		static function longint qmul(longint a, longint b);
			return (a * b) / ONE_Q30;
		endfunction

		// sine and cosine of half the angle, Q.30
		static function void half_trig(angle_t ang, output longint s, output longint c);
			longint h, x2, ts, tc;
			bit     flip, neg;
			h    = longint'(ang) * 65536;
			flip = 0;
			neg  = 0;
			if (h > HPI_Q30) begin
				h    = h - PI_Q30;
				flip = 1;
			end else if (h < -HPI_Q30) begin
				h    = h + PI_Q30;
				flip = 1;
			end
			if (h < 0) begin
				h   = -h;
				neg = 1;
			end
			x2 = qmul(h, h);
			ts = ONE_Q30;
			tc = ONE_Q30;
			for (int k = 8; k >= 1; k--) begin
				ts = ONE_Q30 - qmul(x2, ts) / longint'((2 * k) * (2 * k + 1));
				tc = ONE_Q30 - qmul(x2, tc) / longint'((2 * k - 1) * (2 * k));
			end
			s = qmul(h, ts);
			c = tc;
			if (neg) s = -s;
			if (flip) begin
				s = -s;
				c = -c;
			end
		endfunction

		static function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b   = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		static function qcomp_t to_q14(longint comp, longint unsigned norm);
			longint unsigned mag, q;
			if (norm == 0) return '0;
			mag = (comp < 0) ? -comp : comp;
			q   = ((mag << (QUAT_W - 2)) + norm / 2) / norm;
			if (q > (64'd1 << (QUAT_W - 2))) q = 64'd1 << (QUAT_W - 2);
			if (comp < 0) q = -q;
			return qcomp_t'(q);
		endfunction

		static function quat_t rotation(angles_t a);
			longint s1, c1, s2, c2, s3, c3, cc, ss, sc, cs, w, x, y, z;
			longint unsigned norm;
			quat_t q;
			half_trig(a.roll_angle, s1, c1);
			half_trig(a.pitch_angle, s2, c2);
			half_trig(a.yaw_angle, s3, c3);
			cc   = qmul(c1, c2);
			ss   = qmul(s1, s2);
			sc   = qmul(s1, c2);
			cs   = qmul(c1, s2);
			w    = qmul(cc, c3) - qmul(ss, s3);
			x    = qmul(sc, c3) + qmul(cs, s3);
			y    = qmul(cs, c3) - qmul(sc, s3);
			z    = qmul(cc, s3) + qmul(ss, c3);
			norm = int_sqrt(w * w + x * x + y * y + z * z);
			q.quat_w = to_q14(w, norm);
			q.quat_x = to_q14(x, norm);
			q.quat_y = to_q14(y, norm);
			q.quat_z = to_q14(z, norm);
			return q;
		endfunction

		task report(string what, int got, int want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endtask

		function void note(angles_t a);
			pending.push_back(rotation(a));
		endfunction

		task check(quat_t got);
			quat_t want;
			if (pending.size() == 0) begin
				report("unexpected beat", got.quat_w, 0);
			end else begin
				want = pending.pop_front();
				if (got.quat_w !== want.quat_w) report("quat_w", got.quat_w, want.quat_w);
				if (got.quat_x !== want.quat_x) report("quat_x", got.quat_x, want.quat_x);
				if (got.quat_y !== want.quat_y) report("quat_y", got.quat_y, want.quat_y);
				if (got.quat_z !== want.quat_z) report("quat_z", got.quat_z, want.quat_z);
			end
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	logic    angles_valid;
	logic    angles_ready;
	angles_t angles;
	logic    quat_valid;
	logic    quat_ready;
	quat_t   quat;

	quat_scoreboard sb;
	bit quiet;
	int cycles;

	euler_to_quaternion dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.angles_valid(angles_valid),
		.angles_ready(angles_ready),
		.angles      (angles),
		.quat_valid  (quat_valid),
		.quat_ready  (quat_ready),
		.quat        (quat)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb           = new();
		arst_n       = 0;
		angles_valid = 0;
		angles       = '0;
		quat_ready   = 0;
		quiet        = 0;
		cycles       = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("euler_to_quaternion_tb: FAIL");
			$finish;
		end
	end

	// output stalls in bursts
	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) begin
			quat_ready <= 1;
		end else if (stall_left > 0) begin
			quat_ready <= 0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			quat_ready <= 0;
			stall_left <= $urandom_range(0, 9);
		end else begin
			quat_ready <= 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && quat_valid && quat_ready) sb.check(quat);
	end

	function automatic angle_t rand_angle();
		if ($urandom_range(0, 6) == 0) return angle_t'($urandom);
		return angle_t'(int'($urandom_range(0, 51472)) - 25736);
	endfunction

	task send(angle_t r, angle_t p, angle_t y);
		angles_t a;
		int gap;
		a.roll_angle  = r;
		a.pitch_angle = p;
		a.yaw_angle   = y;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			angles_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		angles_valid <= 1;
		angles       <= a;
		do @(posedge clk); while (!angles_ready);
		sb.note(a);
	endtask

	initial begin
		angle_t edges[10];
		int wait_cnt;
		edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd25735, -16'sd25735,
		          16'sd32767, -16'sd32768, 16'sd12868, -16'sd12868, 16'sd1};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// corners: zero, plus and minus pi, the half angle fold, full field range
		for (int i = 0; i < 10; i++) send(edges[i], edges[i], edges[i]);
		for (int i = 0; i < 10; i++) send(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10]);
		send(16'sd25736, 16'sd0, 16'sd0);
		send(16'sd0, -16'sd25736, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd32767);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 300) begin
				// let the pipe drain completely before resuming
				angles_valid <= 0;
				do @(posedge clk); while (sb.pending.size() != 0);
			end
			if (i == N_RANDOM - 100) quiet = 1;
			send(rand_angle(), rand_angle(), rand_angle());
		end
		angles_valid <= 0;

		wait_cnt = 0;
		while (sb.pending.size() != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("euler_to_quaternion_tb: PASS");
		end else begin
			$display("euler_to_quaternion_tb: FAIL");
		end
		$finish;
	end
endmodule
